// ===== rtl/core/sustained_note_release_pool_core_macros.svh =====
// Assertion helpers for the note release pool.
`ifndef SUSTAINED_NOTE_RELEASE_POOL_CORE_MACROS_SVH
`define SUSTAINED_NOTE_RELEASE_POOL_CORE_MACROS_SVH

// Check that a condition implies a consequence at the same edge.
`define SNRP_ASSERT_IMP(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Check that a condition implies a consequence at the next edge.
`define SNRP_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/core/snrp_pkg.sv =====
package snrp_pkg;

  localparam int POOL_DEPTH = 24;
  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int REM_W = 21;
  localparam int FRAC_W = 16;
  localparam logic [7:0] CROSSFADE_RESET = 8'd10;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_TRIM  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_MISS = 2'd2;

  typedef struct packed {
    logic [3:0]        player;
    logic [3:0]        channel;
    logic [6:0]        note;
    logic [REM_W-1:0]  remaining;
    logic [FRAC_W-1:0] fraction;
  } entry_t;

endpackage

// ===== rtl/core/sustained_note_release_pool_core.sv =====
// Flow: an accepted item is walked over the pool entries in state WALK, and its
// status word is loaded from state DONE; note-off words come out during a tick
// walk, one per cycle while out does not stall, held while out stalls.
// A new item is taken only in IDLE, after the status word of the last one. The
// single entry walker visits one stored entry per cycle, but waits at an expired entry while out stalls.
// Reset: rst (synchronous) empties the pool and loads crossfade with 10.
module sustained_note_release_pool_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [3:0]  player_id,
  input  logic [3:0]  channel,
  input  logic [6:0]  note,
  input  logic [19:0] tick_count,
  input  logic [23:0] step_fixed,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [3:0]  off_player,
  output logic [3:0]  off_channel,
  output logic [6:0]  off_note,
  output logic [1:0]  status,
  output logic [19:0] longest_remaining,
  output logic        last
);
  import snrp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Pool storage: a register file walked by one shared entry unit. Entries
  // are compacted: the walker reads index rd and writes wr, or rd for an add.
  entry_t pool [POOL_DEPTH];
  logic [CNT_W-1:0] active_count;
  logic [7:0] crossfade;

  logic [1:0]  state;
  logic [CNT_W-1:0] rd;    // read pointer
  logic [CNT_W-1:0] wr;    // keep pointer
  logic [1:0]  r_func;
  logic [3:0]  r_player, r_channel;
  logic [6:0]  r_note;
  logic [REM_W-1:0] r_target;
  logic [23:0] r_step;
  logic [1:0]  r_status;
  logic [REM_W-1:0] longest;
  entry_t carry;           // add: entry pushed down the pool

  // Shared entry unit: the step add, remaining update and compares for one entry.
  entry_t cur;
  logic [24:0] acc;
  logic [REM_W-1:0] new_rem;
  logic mine, expire, match;
  logic [REM_W-1:0] keep_rem;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cur = pool[rd[IDX_W-1:0]];
    mine = (cur.player == r_player);
    acc = {1'b0, r_step} + {9'd0, cur.fraction};
    new_rem = cur.remaining - REM_W'(acc[24:16]);
    expire = mine && $signed(new_rem) < 0;
    match = mine && cur.channel == r_channel && cur.note == r_note &&
            $signed(cur.remaining) >= $signed(r_target) && r_status == STAT_MISS;
    keep_rem = cur.remaining;
    if (r_func == FUNC_TICK && mine) keep_rem = new_rem;
    else if (r_func == FUNC_TRIM && match) keep_rem = r_target;
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // Load the output register with a note-off during a tick walk, or with the
  // status word at the finish.
  logic emit_off, emit_stat;
  assign emit_off = (state == ST_WALK) && (r_func == FUNC_TICK) &&
                    (rd < active_count) && expire && out_free;
  assign emit_stat = (state == ST_DONE) && out_free;

  // Add on a full pool: walk without change, only for the maximum.
  logic add_full;
  assign add_full = (func == FUNC_ADD) && (active_count == CNT_W'(POOL_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      active_count <= '0;
      crossfade <= CROSSFADE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) crossfade <= cfg_wdata;
      if (emit_off || emit_stat) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            r_func <= add_full ? FUNC_TRIM : func;
            r_player <= add_full ? ~player_id : player_id;
            r_channel <= add_full ? ~channel : channel;
            r_note <= add_full ? ~note : note;
            r_step <= step_fixed;
            r_target <= add_full ? {1'b0, {(REM_W-1){1'b1}}}
                                 : ({1'b0, tick_count} - {13'd0, crossfade});
            r_status <= add_full ? STAT_FULL :
                        (func == FUNC_TRIM) ? STAT_MISS : STAT_OK;
            carry <= {player_id, channel, note, {1'b0, tick_count}, {FRAC_W{1'b0}}};
            rd <= '0;
            wr <= '0;
            longest <= '0;
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (r_func == FUNC_ADD && rd <= active_count) begin
            // Shift down one entry per cycle, carrying the displaced one.
            pool[rd[IDX_W-1:0]] <= carry;
            carry <= cur;
            if ($signed(carry.remaining) > $signed(longest))
              longest <= carry.remaining;
            rd <= rd + 1'b1;
            if (rd == active_count) begin
              active_count <= active_count + 1'b1;
              state <= ST_DONE;
            end
          end else if (r_func != FUNC_ADD && rd < active_count) begin
            if (r_func == FUNC_TICK && expire) begin
              if (out_free) begin
                kind <= 1'b0;
                off_player <= cur.player;
                off_channel <= cur.channel;
                off_note <= cur.note;
                status <= STAT_OK;
                longest_remaining <= '0;
                last <= 1'b0;
                rd <= rd + 1'b1;
              end
            end else if (r_func == FUNC_CLEAR && mine) begin
              rd <= rd + 1'b1;
            end else begin
              pool[wr[IDX_W-1:0]] <= '{cur.player, cur.channel, cur.note, keep_rem,
                                      (r_func == FUNC_TICK && mine) ? acc[15:0]
                                                                    : cur.fraction};
              if (match && r_func == FUNC_TRIM) r_status <= STAT_OK;
              if ($signed(keep_rem) > $signed(longest)) longest <= keep_rem;
              wr <= wr + 1'b1;
              rd <= rd + 1'b1;
            end
          end else begin
            if (r_func != FUNC_ADD) active_count <= wr;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            kind <= 1'b1;
            off_player <= '0;
            off_channel <= '0;
            off_note <= '0;
            status <= r_status;
            longest_remaining <= longest[19:0];
            last <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`include "sustained_note_release_pool_core_macros.svh"

  `SNRP_ASSERT_IMP(a_count_range, 1'b1, active_count <= CNT_W'(POOL_DEPTH), "pool overfilled")
  `SNRP_ASSERT_IMP(a_last_kind, out_valid, last == kind, "last and kind disagree")
  `SNRP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, state == ST_WALK,
                    "walk did not start")

endmodule
